/* hdl/plu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plu_pkg: shared definitions for the load address and extend unit
// Load mode codes, address form codes and the control group passed from
// the address generator to the top level.
// ----------------------------------------------------------------------------
package plu_pkg;

  localparam int unsigned ModeW = 4;
  localparam int unsigned FormW = 2;
  localparam int unsigned RegW  = 5;
  localparam int unsigned XLen  = 64;

  // load modes
  localparam logic [ModeW-1:0] MODE_LBZ   = 4'd0;
  localparam logic [ModeW-1:0] MODE_LHZ   = 4'd1;
  localparam logic [ModeW-1:0] MODE_LHA   = 4'd2;
  localparam logic [ModeW-1:0] MODE_LWZ   = 4'd3;
  localparam logic [ModeW-1:0] MODE_LWA   = 4'd4;
  localparam logic [ModeW-1:0] MODE_LD    = 4'd5;
  localparam logic [ModeW-1:0] MODE_LHBRX = 4'd6;
  localparam logic [ModeW-1:0] MODE_LWBRX = 4'd7;
  localparam logic [ModeW-1:0] MODE_LFS   = 4'd8;
  localparam logic [ModeW-1:0] MODE_LFD   = 4'd9;
  localparam logic [ModeW-1:0] MODE_LWARX = 4'd10;
  localparam logic [ModeW-1:0] MODE_LDARX = 4'd11;

  // address forms
  localparam logic [FormW-1:0] FORM_D  = 2'd0;
  localparam logic [FormW-1:0] FORM_DS = 2'd1;
  localparam logic [FormW-1:0] FORM_X  = 2'd2;

  // doubleword alignment mask
  localparam logic [2:0] ALIGN8_MASK = 3'h7;

  typedef struct packed {
    logic base_write;  // rA receives the effective address
    logic reserve;     // lwarx / ldarx
  } agen_ctl_t;

endpackage : plu_pkg
`default_nettype wire

/* hdl/power_load_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// power_load_unit: PowerPC load address and extend unit
// Forms the effective address of one decoded load and formats the loaded
// value for the destination register.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a beat is taken at a rising edge with start_i high and
//   busy_o low. busy_o is always low: a new load may be issued every cycle.
//   Result channel: done_o is high for exactly one cycle with the result
//   fields; the receiver takes it at the edge that ends that cycle and
//   cannot stall it, so no backpressure exists anywhere.
//   Stages: input register, then the address adder and data formatter, then
//   the result register. Throughput: one load per cycle.
//   Every command gives exactly one result, including unused modes (which
//   write nothing) and misaligned ldarx (align_fault_o, no dest write).
//   Reserve loads (lwarx, ldarx) set an internal reservation to the
//   effective address when they pass the formatting stage, also on fault.
//   Reset (rst_ni low, asynchronous) empties both stages and clears the
//   reservation; no result appears until a new command is taken.
// ----------------------------------------------------------------------------
module power_load_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // command
  input  wire logic                      start_i,
  output logic                           busy_o,
  input  wire logic [plu_pkg::ModeW-1:0] mode_i,
  input  wire logic [plu_pkg::FormW-1:0] addr_form_i,
  input  wire logic                      update_i,
  input  wire logic [plu_pkg::RegW-1:0]  base_index_i,
  input  wire logic [plu_pkg::XLen-1:0]  base_value_i,
  input  wire logic [plu_pkg::XLen-1:0]  index_value_i,
  input  wire logic signed [15:0]        displacement_i,
  input  wire logic [plu_pkg::XLen-1:0]  mem_data_i,
  input  wire logic [plu_pkg::RegW-1:0]  dest_index_i,
  // result
  output logic                           done_o,
  output logic      [plu_pkg::XLen-1:0]  eff_addr_o,
  output logic      [plu_pkg::XLen-1:0]  dest_value_o,
  output logic      [plu_pkg::RegW-1:0]  dest_reg_o,
  output logic                           dest_is_float_o,
  output logic                           dest_write_o,
  output logic                           base_write_o,
  output logic      [plu_pkg::RegW-1:0]  base_reg_o,
  output logic                           align_fault_o
);

  logic accept;

  // input register
  logic                      in_vld_q;
  logic [plu_pkg::ModeW-1:0] mode_q;
  logic [plu_pkg::FormW-1:0] form_q;
  logic                      update_q;
  logic [plu_pkg::RegW-1:0]  bidx_q;
  logic [plu_pkg::XLen-1:0]  bval_q;
  logic [plu_pkg::XLen-1:0]  xval_q;
  logic signed [15:0]        disp_q;
  logic [plu_pkg::XLen-1:0]  mem_q;
  logic [plu_pkg::RegW-1:0]  didx_q;

  // combinational stage
  logic [plu_pkg::XLen-1:0]  ea_d;
  plu_pkg::agen_ctl_t        actl;
  logic [plu_pkg::XLen-1:0]  val_d;
  logic                      isf_d;
  logic                      dwr_d;
  logic                      fault_d;

  // result register
  logic                      out_vld_q;
  logic [plu_pkg::XLen-1:0]  ea_q;
  logic [plu_pkg::XLen-1:0]  val_q;
  logic [plu_pkg::RegW-1:0]  dreg_q;
  logic                      isf_q;
  logic                      dwr_q;
  logic                      bwr_q;
  logic [plu_pkg::RegW-1:0]  breg_q;
  logic                      fault_q;

  // reservation
  logic                      rsv_vld_q;
  logic [plu_pkg::XLen-1:0]  rsv_addr_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= mode_i;
      form_q   <= addr_form_i;
      update_q <= update_i;
      bidx_q   <= base_index_i;
      bval_q   <= base_value_i;
      xval_q   <= index_value_i;
      disp_q   <= displacement_i;
      mem_q    <= mem_data_i;
      didx_q   <= dest_index_i;
    end
  end

  plu_agen u_agen (
    .mode_i        (mode_q),
    .addr_form_i   (form_q),
    .update_i      (update_q),
    .base_index_i  (bidx_q),
    .base_value_i  (bval_q),
    .index_value_i (xval_q),
    .displacement_i(disp_q),
    .eff_addr_o    (ea_d),
    .ctl_o         (actl)
  );

  plu_fmt u_fmt (
    .mode_i         (mode_q),
    .mem_data_i     (mem_q),
    .ea_low_i       (ea_d[2:0]),
    .dest_value_o   (val_d),
    .dest_is_float_o(isf_d),
    .dest_write_o   (dwr_d),
    .align_fault_o  (fault_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      rsv_vld_q  <= 1'b0;
      rsv_addr_q <= '0;
    end else begin
      out_vld_q <= in_vld_q;
      // reservation is set even when ldarx faults
      if (in_vld_q && actl.reserve) begin
        rsv_vld_q  <= 1'b1;
        rsv_addr_q <= ea_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      ea_q    <= ea_d;
      val_q   <= val_d;
      dreg_q  <= didx_q;
      isf_q   <= isf_d;
      dwr_q   <= dwr_d;
      bwr_q   <= actl.base_write;
      breg_q  <= bidx_q;
      fault_q <= fault_d;
    end
  end

  assign done_o          = out_vld_q;
  assign eff_addr_o      = ea_q;
  assign dest_value_o    = val_q;
  assign dest_reg_o      = dreg_q;
  assign dest_is_float_o = isf_q;
  assign dest_write_o    = dwr_q;
  assign base_write_o    = bwr_q;
  assign base_reg_o      = breg_q;
  assign align_fault_o   = fault_q;

endmodule : power_load_unit
`default_nettype wire

/* hdl/plu_agen.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plu_agen: effective address generator
// Picks the offset for D, DS or indexed form, applies the rA=0 rule and
// adds. Also decides base writeback and reserve.
// ----------------------------------------------------------------------------
module plu_agen (
  input  wire logic [plu_pkg::ModeW-1:0] mode_i,
  input  wire logic [plu_pkg::FormW-1:0] addr_form_i,
  input  wire logic                      update_i,
  input  wire logic [plu_pkg::RegW-1:0]  base_index_i,
  input  wire logic [plu_pkg::XLen-1:0]  base_value_i,
  input  wire logic [plu_pkg::XLen-1:0]  index_value_i,
  input  wire logic signed [15:0]        displacement_i,
  output logic      [plu_pkg::XLen-1:0]  eff_addr_o,
  output plu_pkg::agen_ctl_t             ctl_o
);

  logic                     reserve;
  logic                     valid_mode;
  logic                     upd;
  logic [plu_pkg::FormW-1:0] form;
  logic [plu_pkg::XLen-1:0] off;
  logic [plu_pkg::XLen-1:0] base;

  always_comb begin
    reserve    = (mode_i == plu_pkg::MODE_LWARX) || (mode_i == plu_pkg::MODE_LDARX);
    valid_mode = (mode_i <= plu_pkg::MODE_LDARX);
    form       = addr_form_i;
    upd        = update_i;
    if (reserve) begin
      form = plu_pkg::FORM_X;
      upd  = 1'b0;
    end
    // lwa and ld have no D form
    if (((mode_i == plu_pkg::MODE_LWA) || (mode_i == plu_pkg::MODE_LD)) &&
        (form == plu_pkg::FORM_D)) begin
      form = plu_pkg::FORM_DS;
    end
    if (!valid_mode) begin
      upd = 1'b0;
    end

    case (form)
      plu_pkg::FORM_D:  off = {{48{displacement_i[15]}}, displacement_i};
      plu_pkg::FORM_DS: off = {{48{displacement_i[13]}}, displacement_i[13:0], 2'b00};
      default:          off = index_value_i;  // indexed, form 3 too
    endcase

    base = (upd || (base_index_i != '0)) ? base_value_i : '0;
    eff_addr_o       = base + off;
    ctl_o.base_write = upd;
    ctl_o.reserve    = reserve;
  end

endmodule : plu_agen
`default_nettype wire

/* hdl/plu_fmt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plu_fmt: load data formatter
// Size masking, sign extension, byte reversal and exact single-to-double
// widening; flags the misaligned ldarx fault.
// ----------------------------------------------------------------------------
module plu_fmt (
  input  wire logic [plu_pkg::ModeW-1:0] mode_i,
  input  wire logic [plu_pkg::XLen-1:0]  mem_data_i,
  input  wire logic [2:0]                ea_low_i,
  output logic      [plu_pkg::XLen-1:0]  dest_value_o,
  output logic                           dest_is_float_o,
  output logic                           dest_write_o,
  output logic                           align_fault_o
);

  // single to double, exact; denormals are normalized, NaN payload kept
  function automatic logic [63:0] widen_single(input logic [31:0] v);
    logic        s;
    logic [7:0]  e;
    logic [22:0] f;
    logic [10:0] ex;
    logic [22:0] fr;
    logic [4:0]  msb;
    logic [4:0]  sh;
    s   = v[31];
    e   = v[30:23];
    f   = v[22:0];
    msb = '0;
    for (int i = 0; i < 23; i++) begin
      if (f[i]) msb = 5'(i);
    end
    sh = 5'd23 - msb;
    if (e == 8'hff) begin
      ex = 11'h7ff;
      fr = f;
    end else if (e == 8'h00) begin
      if (f == '0) begin
        ex = '0;
        fr = '0;
      end else begin
        ex = 11'd874 + {6'd0, msb};
        fr = f << sh;
      end
    end else begin
      ex = {3'd0, e} + 11'd896;
      fr = f;
    end
    return {s, ex, fr, 29'd0};
  endfunction

  logic [plu_pkg::XLen-1:0] val;
  logic                     isf;
  logic                     valid_mode;
  logic                     fault;

  always_comb begin
    isf = 1'b0;
    case (mode_i)
      plu_pkg::MODE_LBZ:   val = {56'd0, mem_data_i[7:0]};
      plu_pkg::MODE_LHZ:   val = {48'd0, mem_data_i[15:0]};
      plu_pkg::MODE_LHA:   val = {{48{mem_data_i[15]}}, mem_data_i[15:0]};
      plu_pkg::MODE_LWZ,
      plu_pkg::MODE_LWARX: val = {32'd0, mem_data_i[31:0]};
      plu_pkg::MODE_LWA:   val = {{32{mem_data_i[31]}}, mem_data_i[31:0]};
      plu_pkg::MODE_LD,
      plu_pkg::MODE_LDARX: val = mem_data_i;
      plu_pkg::MODE_LHBRX: val = {48'd0, mem_data_i[7:0], mem_data_i[15:8]};
      plu_pkg::MODE_LWBRX: val = {32'd0, mem_data_i[7:0], mem_data_i[15:8],
                                  mem_data_i[23:16], mem_data_i[31:24]};
      plu_pkg::MODE_LFS: begin
        val = widen_single(mem_data_i[31:0]);
        isf = 1'b1;
      end
      plu_pkg::MODE_LFD: begin
        val = mem_data_i;
        isf = 1'b1;
      end
      default:             val = '0;
    endcase

    valid_mode = (mode_i <= plu_pkg::MODE_LDARX);
    fault      = (mode_i == plu_pkg::MODE_LDARX) &&
                 ((ea_low_i & plu_pkg::ALIGN8_MASK) != 3'd0);

    dest_value_o    = fault ? '0 : val;
    dest_is_float_o = isf;
    dest_write_o    = valid_mode && !fault;
    align_fault_o   = fault;
  end

endmodule : plu_fmt
`default_nettype wire

/* hdl/plu_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plu_checker: port-level checks for the load unit
// Result timing against commands and consistency of the fault flags.
// ----------------------------------------------------------------------------
module plu_checker (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     start_i,
  input wire logic                     busy_o,
  input wire logic                     done_o,
  input wire logic [plu_pkg::XLen-1:0] dest_value_o,
  input wire logic                     dest_is_float_o,
  input wire logic                     dest_write_o,
  input wire logic                     base_write_o,
  input wire logic                     align_fault_o
);

  // every command gives a result through the input and result registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("plu: result missing two cycles after command");

  // no result without a matching earlier command
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("plu: result without a command");

  // a faulting beat writes nothing and returns zero
  a_fault_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && align_fault_o) |->
      (!dest_write_o && !base_write_o && (dest_value_o == '0)))
    else $error("plu: faulting load writes a register");

  // only ldarx faults, never a float load
  a_fault_int: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && dest_is_float_o) |-> !align_fault_o)
    else $error("plu: float load flagged with alignment fault");

endmodule : plu_checker

bind power_load_unit plu_checker u_plu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .dest_value_o   (dest_value_o),
  .dest_is_float_o(dest_is_float_o),
  .dest_write_o   (dest_write_o),
  .base_write_o   (base_write_o),
  .align_fault_o  (align_fault_o)
);
`default_nettype wire

/* verif/power_load_unit_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// power_load_unit_checker: result predictor and scoreboard
// Watches the command and result channels of the load unit. Each accepted
// command beat is turned into an expected result; each result beat is
// compared field by field with the oldest one. Counts go back to the bench.
// ----------------------------------------------------------------------------
module power_load_unit_checker (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // command channel
  input  wire logic                      start_i,
  input  wire logic                      busy_i,
  input  wire logic [plu_pkg::ModeW-1:0] mode_i,
  input  wire logic [plu_pkg::FormW-1:0] addr_form_i,
  input  wire logic                      update_i,
  input  wire logic [plu_pkg::RegW-1:0]  base_index_i,
  input  wire logic [plu_pkg::XLen-1:0]  base_value_i,
  input  wire logic [plu_pkg::XLen-1:0]  index_value_i,
  input  wire logic [15:0]               displacement_i,
  input  wire logic [plu_pkg::XLen-1:0]  mem_data_i,
  input  wire logic [plu_pkg::RegW-1:0]  dest_index_i,
  // result channel
  input  wire logic                      done_i,
  input  wire logic [plu_pkg::XLen-1:0]  eff_addr_i,
  input  wire logic [plu_pkg::XLen-1:0]  dest_value_i,
  input  wire logic [plu_pkg::RegW-1:0]  dest_reg_i,
  input  wire logic                      dest_is_float_i,
  input  wire logic                      dest_write_i,
  input  wire logic                      base_write_i,
  input  wire logic [plu_pkg::RegW-1:0]  base_reg_i,
  input  wire logic                      align_fault_i,
  // counts
  output logic [31:0]                    mismatch_cnt_o,
  output logic [31:0]                    pending_cnt_o,
  output logic [31:0]                    checked_cnt_o,
  output logic [31:0]                    fault_cnt_o
);

  typedef struct packed {
    logic [plu_pkg::XLen-1:0] eff_addr;
    logic [plu_pkg::XLen-1:0] dest_value;
    logic [plu_pkg::RegW-1:0] dest_reg;
    logic                     dest_is_float;
    logic                     dest_write;
    logic                     base_write;
    logic [plu_pkg::RegW-1:0] base_reg;
    logic                     align_fault;
  } load_result_t;

  load_result_t             load_results_q[$];
  load_result_t             want;
  load_result_t             got;
  logic                     resv_valid;
  logic [plu_pkg::XLen-1:0] resv_addr;
  logic                     bad;
  logic                     popped;
  logic                     pushed;

  // exact single to double widening; NaN payload kept as is
  function automatic logic [63:0] single_to_double(input logic [31:0] s);
    logic [10:0] exp_d;
    logic [23:0] frac;
    frac = {1'b0, s[22:0]};
    if (s[30:23] == 8'hff) begin
      exp_d = 11'h7ff;
    end else if (s[30:23] == 8'h00) begin
      if (frac == '0) begin
        exp_d = '0;
      end else begin
        // normalize the denormal
        exp_d = 11'd897;
        for (int i = 0; i < 24; i++) begin
          if (!frac[23]) begin
            frac  = frac << 1;
            exp_d = exp_d - 11'd1;
          end
        end
      end
    end else begin
      exp_d = {3'b000, s[30:23]} + 11'd896;
    end
    return {s[31], exp_d, frac[22:0], 29'b0};
  endfunction

  function automatic load_result_t predict_load(
    input logic [plu_pkg::ModeW-1:0] mode,
    input logic [plu_pkg::FormW-1:0] form_in,
    input logic                      upd_in,
    input logic [plu_pkg::RegW-1:0]  bidx,
    input logic [plu_pkg::XLen-1:0]  bval,
    input logic [plu_pkg::XLen-1:0]  xval,
    input logic [15:0]               disp,
    input logic [plu_pkg::XLen-1:0]  mem,
    input logic [plu_pkg::RegW-1:0]  didx
  );
    logic [plu_pkg::FormW-1:0] form;
    logic                      upd;
    logic                      reserve;
    logic                      known;
    logic [plu_pkg::XLen-1:0]  offs;
    logic [plu_pkg::XLen-1:0]  base;
    load_result_t              r;
    reserve = (mode == plu_pkg::MODE_LWARX) || (mode == plu_pkg::MODE_LDARX);
    known   = (mode <= plu_pkg::MODE_LDARX);
    form    = reserve ? plu_pkg::FORM_X : form_in;
    upd     = upd_in && !reserve && known;
    // lwa and ld have no D form
    if ((mode == plu_pkg::MODE_LWA || mode == plu_pkg::MODE_LD) && form == plu_pkg::FORM_D)
      form = plu_pkg::FORM_DS;
    if (form >= plu_pkg::FORM_X) offs = xval;
    else if (form == plu_pkg::FORM_DS) offs = {{48{disp[13]}}, disp[13:0], 2'b00};
    else offs = {{48{disp[15]}}, disp};
    base = (upd || bidx != '0) ? bval : '0;
    r            = '0;
    r.eff_addr   = base + offs;
    r.dest_reg   = didx;
    r.base_reg   = bidx;
    r.base_write = upd;
    case (mode)
      plu_pkg::MODE_LBZ:   r.dest_value = {56'b0, mem[7:0]};
      plu_pkg::MODE_LHZ:   r.dest_value = {48'b0, mem[15:0]};
      plu_pkg::MODE_LHA:   r.dest_value = {{48{mem[15]}}, mem[15:0]};
      plu_pkg::MODE_LWZ,
      plu_pkg::MODE_LWARX: r.dest_value = {32'b0, mem[31:0]};
      plu_pkg::MODE_LWA:   r.dest_value = {{32{mem[31]}}, mem[31:0]};
      plu_pkg::MODE_LD,
      plu_pkg::MODE_LDARX: r.dest_value = mem;
      plu_pkg::MODE_LHBRX: r.dest_value = {48'b0, mem[7:0], mem[15:8]};
      plu_pkg::MODE_LWBRX: begin
        r.dest_value = {32'b0, mem[7:0], mem[15:8], mem[23:16], mem[31:24]};
      end
      plu_pkg::MODE_LFS: begin
        r.dest_value    = single_to_double(mem[31:0]);
        r.dest_is_float = 1'b1;
      end
      plu_pkg::MODE_LFD: begin
        r.dest_value    = mem;
        r.dest_is_float = 1'b1;
      end
      default:             r.dest_value = '0;
    endcase
    if (mode == plu_pkg::MODE_LDARX &&
        (r.eff_addr[2:0] & plu_pkg::ALIGN8_MASK) != '0) begin
      r.align_fault = 1'b1;
      r.dest_value  = '0;
    end
    r.dest_write = known && !r.align_fault;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_results_q.delete();
      resv_valid     <= 1'b0;
      resv_addr      <= '0;
      mismatch_cnt_o <= '0;
      pending_cnt_o  <= '0;
      checked_cnt_o  <= '0;
      fault_cnt_o    <= '0;
    end else begin
      bad    = 1'b0;
      popped = 1'b0;
      pushed = 1'b0;
      if (done_i) begin
        got = '{eff_addr_i, dest_value_i, dest_reg_i, dest_is_float_i, dest_write_i,
                base_write_i, base_reg_i, align_fault_i};
        if (load_results_q.size() == 0) begin
          bad = 1'b1;
          if (mismatch_cnt_o < 10) begin
            $display("%0t: result beat with nothing pending: ea=%h val=%h", $realtime,
                     got.eff_addr, got.dest_value);
          end
        end else begin
          want   = load_results_q.pop_front();
          popped = 1'b1;
          if (got !== want) begin
            bad = 1'b1;
            if (mismatch_cnt_o < 10) begin
              $display("%0t: mismatch on result %0d", $realtime, checked_cnt_o);
              $display("  exp ea=%h val=%h rd=%0d fp=%b wr=%b bw=%b ra=%0d af=%b",
                       want.eff_addr, want.dest_value, want.dest_reg, want.dest_is_float,
                       want.dest_write, want.base_write, want.base_reg, want.align_fault);
              $display("  got ea=%h val=%h rd=%0d fp=%b wr=%b bw=%b ra=%0d af=%b",
                       got.eff_addr, got.dest_value, got.dest_reg, got.dest_is_float,
                       got.dest_write, got.base_write, got.base_reg, got.align_fault);
            end
          end
        end
      end
      if (start_i && !busy_i) begin
        want = predict_load(mode_i, addr_form_i, update_i, base_index_i, base_value_i,
                            index_value_i, displacement_i, mem_data_i, dest_index_i);
        load_results_q.push_back(want);
        pushed = 1'b1;
        // reservation is taken even when ldarx faults
        if (mode_i == plu_pkg::MODE_LWARX || mode_i == plu_pkg::MODE_LDARX) begin
          resv_valid <= 1'b1;
          resv_addr  <= want.eff_addr;
        end
        if (want.align_fault) fault_cnt_o <= fault_cnt_o + 1;
      end
      if (bad) mismatch_cnt_o <= mismatch_cnt_o + 1;
      if (popped) checked_cnt_o <= checked_cnt_o + 1;
      pending_cnt_o <= pending_cnt_o + pushed - popped;
    end
  end

endmodule : power_load_unit_checker

/* verif/power_load_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// power_load_unit_tb: stimulus and verdict for the load address/extend unit
// Drives a directed set of loads (every mode, every address form, field
// extremes, float widening corner cases, ldarx alignment) and then a long
// random stream with random sender gaps and gapless stretches. Checking is
// done by the checker instance beside the block.
// ----------------------------------------------------------------------------
module power_load_unit_tb;

  localparam int unsigned    RANDOM_LOADS = 1800;
  localparam int unsigned    CYCLE_LIMIT  = 200000;
  localparam int unsigned    MAX_GAP      = 10;
  // result register sits behind the input register
  localparam int unsigned    TAIL_CYCLES  = 4;
  // unnamed fourth form code; the block treats it as indexed
  localparam logic [plu_pkg::FormW-1:0] FORM_RSVD = 2'd3;
  localparam int unsigned    MODE_COUNT   = 2 ** plu_pkg::ModeW;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start_i;
  logic                          busy_o;
  logic [plu_pkg::ModeW-1:0]     mode_i;
  logic [plu_pkg::FormW-1:0]     addr_form_i;
  logic                          update_i;
  logic [plu_pkg::RegW-1:0]      base_index_i;
  logic [plu_pkg::XLen-1:0]      base_value_i;
  logic [plu_pkg::XLen-1:0]      index_value_i;
  logic signed [15:0]            displacement_i;
  logic [plu_pkg::XLen-1:0]      mem_data_i;
  logic [plu_pkg::RegW-1:0]      dest_index_i;
  logic                          done_o;
  logic [plu_pkg::XLen-1:0]      eff_addr_o;
  logic [plu_pkg::XLen-1:0]      dest_value_o;
  logic [plu_pkg::RegW-1:0]      dest_reg_o;
  logic                          dest_is_float_o;
  logic                          dest_write_o;
  logic                          base_write_o;
  logic [plu_pkg::RegW-1:0]      base_reg_o;
  logic                          align_fault_o;

  logic [31:0]          mismatch_cnt;
  logic [31:0]          pending_cnt;
  logic [31:0]          checked_cnt;
  logic [31:0]          fault_cnt;

  int unsigned          loads_sent;
  logic                 gapless;

  power_load_unit u_top (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .mode_i,
    .addr_form_i,
    .update_i,
    .base_index_i,
    .base_value_i,
    .index_value_i,
    .displacement_i,
    .mem_data_i,
    .dest_index_i,
    .done_o,
    .eff_addr_o,
    .dest_value_o,
    .dest_reg_o,
    .dest_is_float_o,
    .dest_write_o,
    .base_write_o,
    .base_reg_o,
    .align_fault_o
  );

  power_load_unit_checker u_checker (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_i          (busy_o),
    .mode_i,
    .addr_form_i,
    .update_i,
    .base_index_i,
    .base_value_i,
    .index_value_i,
    .displacement_i,
    .mem_data_i,
    .dest_index_i,
    .done_i          (done_o),
    .eff_addr_i      (eff_addr_o),
    .dest_value_i    (dest_value_o),
    .dest_reg_i      (dest_reg_o),
    .dest_is_float_i (dest_is_float_o),
    .dest_write_i    (dest_write_o),
    .base_write_i    (base_write_o),
    .base_reg_i      (base_reg_o),
    .align_fault_i   (align_fault_o),
    .mismatch_cnt_o  (mismatch_cnt),
    .pending_cnt_o   (pending_cnt),
    .checked_cnt_o   (checked_cnt),
    .fault_cnt_o     (fault_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the result channel goes quiet.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb: timeout after %0d cycles, %0d results pending", CYCLE_LIMIT, pending_cnt);
    $display("tb: failure");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // One command beat. Called at a rising edge; the optional idle gap comes
  // first so start_i keeps high between back-to-back beats. Returns at the
  // edge that took the beat.
  task automatic send_load(
    input logic [plu_pkg::ModeW-1:0] mode,
    input logic [plu_pkg::FormW-1:0] form,
    input logic                      upd,
    input logic [plu_pkg::RegW-1:0]  bidx,
    input logic [plu_pkg::XLen-1:0]  bval,
    input logic [plu_pkg::XLen-1:0]  xval,
    input logic [15:0]               disp,
    input logic [plu_pkg::XLen-1:0]  mem,
    input logic [plu_pkg::RegW-1:0]  didx
  );
    int unsigned gap;
    gap = gapless ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    mode_i         <= mode;
    addr_form_i    <= form;
    update_i       <= upd;
    base_index_i   <= bidx;
    base_value_i   <= bval;
    index_value_i  <= xval;
    displacement_i <= disp;
    mem_data_i     <= mem;
    dest_index_i   <= didx;
    do @(posedge clk_i); while (busy_o);
    loads_sent++;
  endtask

  // Sender holds off until every expected result beat has come back.
  task automatic wait_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
  endtask

  // Random load, weighted toward the interesting corners: rA of zero,
  // extreme displacements, float specials for lfs, aligned ldarx at least half the time.
  task automatic send_random_load();
    logic [plu_pkg::ModeW-1:0] mode;
    logic [plu_pkg::XLen-1:0]  bval;
    logic [plu_pkg::XLen-1:0]  xval;
    logic [plu_pkg::XLen-1:0]  mem;
    logic [15:0]               disp;
    logic [plu_pkg::RegW-1:0]  bidx;
    if ($urandom_range(0, 99) < 8) begin
      mode = plu_pkg::ModeW'($urandom_range(plu_pkg::MODE_LDARX + 1, MODE_COUNT - 1));
    end else begin
      mode = plu_pkg::ModeW'($urandom_range(0, plu_pkg::MODE_LDARX));
    end
    bval = rand64();
    xval = rand64();
    mem  = rand64();
    bidx = ($urandom_range(0, 4) == 0) ? '0 : plu_pkg::RegW'($urandom_range(0, 31));
    case ($urandom_range(0, 7))
      0:       disp = 16'h7fff;
      1:       disp = 16'h8000;
      2:       disp = 16'hffff;
      3:       disp = 16'h0000;
      default: disp = 16'($urandom);
    endcase
    if (mode == plu_pkg::MODE_LFS) begin
      case ($urandom_range(0, 4))
        0: mem[30:0] = '0;          // signed zero
        1: mem[30:23] = 8'h00;      // denormal (or zero)
        2: mem[30:23] = 8'hff;      // infinity or NaN
        3: mem[30:23] = 8'hfe;      // largest finite exponent
        default: ;
      endcase
    end
    if (mode == plu_pkg::MODE_LDARX && $urandom_range(0, 1) == 1) begin
      bval[2:0] = '0;
      xval[2:0] = '0;
    end
    send_load(mode, plu_pkg::FormW'($urandom_range(0, 3)), 1'($urandom), bidx, bval, xval,
              disp, mem, plu_pkg::RegW'($urandom_range(0, 31)));
  endtask

  initial begin
    loads_sent     = 0;
    gapless        = 1'b0;
    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    mode_i         <= '0;
    addr_form_i    <= '0;
    update_i       <= 1'b0;
    base_index_i   <= '0;
    base_value_i   <= '0;
    index_value_i  <= '0;
    displacement_i <= '0;
    mem_data_i     <= '0;
    dest_index_i   <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    // lbz, rA zero reads as zero, largest positive d, high mem bits ignored
    send_load(plu_pkg::MODE_LBZ, plu_pkg::FORM_D, 1'b0, 5'd0, '1, '0, 16'h7fff, '1, 5'd0);
    // lhz with update on r0: base is used and written back, most negative d
    send_load(plu_pkg::MODE_LHZ, plu_pkg::FORM_D, 1'b1, 5'd0, 64'h0000_0000_0001_0000, '0,
              16'h8000, 64'hffff_ffff_ffff_8001, 5'd31);
    // lha sign extension, negative then positive halfword
    send_load(plu_pkg::MODE_LHA, plu_pkg::FORM_D, 1'b0, 5'd31, 64'h1000, '0, 16'hffff,
              64'h0000_0000_0000_8000, 5'd1);
    send_load(plu_pkg::MODE_LHA, plu_pkg::FORM_X, 1'b1, 5'd3, 64'h2000, 64'h10, '0,
              64'hffff_ffff_ffff_7fff, 5'd2);
    // lwz indexed, address wraps modulo 2^64
    send_load(plu_pkg::MODE_LWZ, plu_pkg::FORM_X, 1'b0, 5'd31, '1, '1, '0,
              64'h8765_4321_ffff_ffff, 5'd4);
    // lwa in D form is promoted to DS; ds sign bit set
    send_load(plu_pkg::MODE_LWA, plu_pkg::FORM_D, 1'b0, 5'd5, 64'h4000, '0, 16'h2001,
              64'h0000_0000_8000_0000, 5'd5);
    // ld in DS form: bits above ds are dropped
    send_load(plu_pkg::MODE_LD, plu_pkg::FORM_DS, 1'b1, 5'd6, 64'h8000_0000_0000_0000, '0,
              16'hffff, 64'h0123_4567_89ab_cdef, 5'd6);
    // byte reversal, high bits set to show they are ignored
    send_load(plu_pkg::MODE_LHBRX, plu_pkg::FORM_X, 1'b0, 5'd7, 64'h100, 64'h1, '0,
              64'hffff_ffff_ffff_1234, 5'd7);
    send_load(plu_pkg::MODE_LWBRX, plu_pkg::FORM_X, 1'b0, 5'd8, 64'h100, 64'h3, '0,
              64'hffff_ffff_1234_5678, 5'd8);
    // single widening: one, negative zero, smallest and largest denormal,
    // infinity, signaling NaN (payload kept), largest finite
    send_load(plu_pkg::MODE_LFS, plu_pkg::FORM_D, 1'b0, 5'd9, 64'h200, '0, 16'h4,
              64'h3f80_0000, 5'd9);
    send_load(plu_pkg::MODE_LFS, plu_pkg::FORM_D, 1'b0, 5'd9, 64'h200, '0, 16'h4,
              64'hffff_ffff_8000_0000, 5'd10);
    send_load(plu_pkg::MODE_LFS, plu_pkg::FORM_DS, 1'b0, 5'd9, 64'h200, '0, 16'h1,
              64'h0000_0001, 5'd11);
    send_load(plu_pkg::MODE_LFS, plu_pkg::FORM_X, 1'b0, 5'd9, 64'h200, 64'h8, '0,
              64'h807f_ffff, 5'd12);
    send_load(plu_pkg::MODE_LFS, plu_pkg::FORM_D, 1'b1, 5'd9, 64'h200, '0, 16'h8,
              64'h7f80_0000, 5'd13);
    send_load(plu_pkg::MODE_LFS, plu_pkg::FORM_D, 1'b0, 5'd9, 64'h200, '0, '0,
              64'h7f80_0001, 5'd14);
    send_load(plu_pkg::MODE_LFS, plu_pkg::FORM_D, 1'b0, 5'd9, 64'h200, '0, '0,
              64'hff7f_ffff, 5'd15);
    send_load(plu_pkg::MODE_LFD, plu_pkg::FORM_D, 1'b1, 5'd10, 64'h300, '0, 16'h8,
              64'hfff8_0000_0000_0001, 5'd16);
    // lwarx: form and update are overridden to indexed, no writeback
    send_load(plu_pkg::MODE_LWARX, plu_pkg::FORM_D, 1'b1, 5'd11, 64'h1000, 64'h4, 16'h7fff,
              64'hdead_beef_cafe_f00d, 5'd17);
    // ldarx aligned, then misaligned (fault, reservation still taken),
    // then with rA zero
    send_load(plu_pkg::MODE_LDARX, plu_pkg::FORM_X, 1'b0, 5'd12, 64'h1000, 64'h8, '0, '1,
              5'd18);
    send_load(plu_pkg::MODE_LDARX, plu_pkg::FORM_DS, 1'b1, 5'd12, 64'h1000, 64'h5, '0, '1,
              5'd19);
    send_load(plu_pkg::MODE_LDARX, plu_pkg::FORM_X, 1'b0, 5'd0, 64'h7, 64'h10, '0, 64'h55,
              5'd20);
    // unnamed fourth form acts as indexed
    send_load(plu_pkg::MODE_LBZ, FORM_RSVD, 1'b1, 5'd13, 64'h40, 64'h2, 16'h100, 64'h80,
              5'd21);
    // unused modes write nothing but still report an address
    for (int m = plu_pkg::MODE_LDARX + 1; m < MODE_COUNT; m++) begin
      send_load(plu_pkg::ModeW'(m), plu_pkg::FORM_D, 1'b1, 5'd14, 64'h500, 64'h1, 16'h10,
                '1, 5'd22);
    end
    wait_drained();

    // ---- random part ----
    // stretches of 64 beats; every third stretch runs with no idle gaps
    for (int i = 0; i < RANDOM_LOADS; i++) begin
      gapless = ((i / 64) % 3 == 1);
      if (i == RANDOM_LOADS / 2) wait_drained();
      send_random_load();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("summary: %0d loads issued, %0d results checked, %0d misaligned ldarx faults",
             loads_sent, checked_cnt, fault_cnt);
    $display("summary: %0d mismatches, %0d results still pending", mismatch_cnt, pending_cnt);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule : power_load_unit_tb
